/* sv/fir2d_pkg.sv */
// Shared constants and types for the two-direction FIR filter.
package fir2d_pkg;

  localparam int unsigned SAMPLE_W      = 32;
  localparam int unsigned COEF_W        = 18;
  localparam int unsigned NUM_COEF      = 6;
  localparam int unsigned COEF_IDX_W    = $clog2(NUM_COEF);
  localparam int unsigned TAP_CNT_W     = 3;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 18;
  localparam int unsigned MAX_TAPS_DEF  = 6;
  localparam int unsigned COEF_FRAC_DEF = 14;
  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam int unsigned PROD_W        = SAMPLE_W + COEF_W;
  localparam int unsigned ACC_W         = PROD_W + $clog2(NUM_COEF);

  localparam logic [COEF_W-1:0]   COEF0_RESET = COEF_W'(16384);
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX  = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic [SAMPLE_W-1:0] SAMPLE_MIN  = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TAP_COUNT,
    REG_DIRECTION,
    REG_COEF_0,
    REG_COEF_1,
    REG_COEF_2,
    REG_COEF_3,
    REG_COEF_4,
    REG_COEF_5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    JOB_PASS,
    JOB_PAST,
    JOB_FUTURE
  } job_kind_e;

  typedef struct packed {
    job_kind_e kind;
    logic      drain;    // emit positions pos down to 0
    logic      blk_end;
  } job_ctl_t;

endpackage

/* sv/fir2d_front.sv */
// Front end: accepts samples, keeps block history and classifies the work per sample.
module fir2d_front import fir2d_pkg::*; #(
  parameter int unsigned MAX_TAPS = MAX_TAPS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [$clog2(MAX_TAPS+1)-1:0]         taps_i,
  input  logic                                  direction_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [SAMPLE_W-1:0]                   sample_i,
  input  logic                                  blk_end_i,
  input  logic                                  q_full_i,
  output logic                                  push_o,
  output logic [MAX_TAPS-1:0][SAMPLE_W-1:0]     job_hist_o,
  output logic [((MAX_TAPS>1)?$clog2(MAX_TAPS):1)-1:0] job_pos_o,
  output job_ctl_t                              job_ctl_o
);

  localparam int unsigned HIST_IDX_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int unsigned FILL_W     = $clog2(MAX_TAPS + 1);

  logic [MAX_TAPS-1:0][SAMPLE_W-1:0] hist_q, hist_d, hist_shift;
  logic [FILL_W-1:0]                 fill_q, fill_d, fill_inc, fill_min;
  logic                              in_xfer;
  logic                              push_en;

  assign in_ready_o = !q_full_i;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign push_o     = in_xfer && push_en;

  always_comb begin
    hist_shift[0] = sample_i;
    for (int i = 1; i < MAX_TAPS; i++) begin
      hist_shift[i] = hist_q[i-1];
    end
  end

  assign fill_inc   = (32'(fill_q) < MAX_TAPS) ? fill_q + 1'b1 : fill_q;
  assign fill_min   = (fill_inc < taps_i) ? fill_inc : taps_i;
  assign job_hist_o = hist_shift;

  always_comb begin
    push_en           = 1'b0;
    job_pos_o         = '0;
    job_ctl_o.kind    = JOB_PASS;
    job_ctl_o.drain   = 1'b0;
    job_ctl_o.blk_end = blk_end_i;
    priority if (taps_i == '0) begin
      push_en = 1'b1;
    end else if (!direction_i) begin
      job_ctl_o.kind = JOB_PAST;
      push_en        = 1'b1;
    end else if (!blk_end_i) begin
      job_ctl_o.kind = JOB_FUTURE;
      job_pos_o      = HIST_IDX_W'(taps_i - 1'b1);
      push_en        = (fill_inc >= taps_i);
    end else begin
      job_ctl_o.kind  = JOB_FUTURE;
      job_ctl_o.drain = 1'b1;
      job_pos_o       = HIST_IDX_W'(fill_min - 1'b1);
      push_en         = 1'b1;
    end
  end

  always_comb begin
    hist_d = hist_q;
    fill_d = fill_q;
    if (in_xfer) begin
      hist_d = blk_end_i ? '0 : hist_shift;
      fill_d = blk_end_i ? '0 : fill_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
      fill_q <= '0;
    end else begin
      hist_q <= hist_d;
      fill_q <= fill_d;
    end
  end

endmodule

/* sv/fir2d_queue.sv */
// Short job queue between the front end and the filter engine.
module fir2d_queue import fir2d_pkg::*; #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  input  logic              pop_i,
  output logic [DATA_W-1:0] data_o,
  output logic              full_o,
  output logic              empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] entry_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (32'(count_q) == DEPTH);
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (32'(wr_ptr_q) == DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (32'(rd_ptr_q) == DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* sv/fir2d_back.sv */
// Filter engine: multiply, sum, round toward zero, saturate and hold the result, or pass the sample through.
module fir2d_back import fir2d_pkg::*; #(
  parameter int unsigned MAX_TAPS       = MAX_TAPS_DEF,
  parameter int unsigned COEF_FRAC_BITS = COEF_FRAC_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [$clog2(MAX_TAPS+1)-1:0]         taps_i,
  input  logic [NUM_COEF-1:0][COEF_W-1:0]       coef_i,
  input  logic                                  q_empty_i,
  output logic                                  pop_o,
  input  logic [MAX_TAPS-1:0][SAMPLE_W-1:0]     job_hist_i,
  input  logic [((MAX_TAPS>1)?$clog2(MAX_TAPS):1)-1:0] job_pos_i,
  input  job_ctl_t                              job_ctl_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [SAMPLE_W-1:0]                   out_data_o,
  output logic                                  out_last_o
);

  localparam int unsigned HIST_IDX_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int unsigned LANES      = (MAX_TAPS < NUM_COEF) ? MAX_TAPS : NUM_COEF;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_SUM  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0] state_q, state_d;

  logic [MAX_TAPS-1:0][SAMPLE_W-1:0] hist_q;
  logic [HIST_IDX_W-1:0]             pos_q, pos_d;
  job_ctl_t                          ctl_q;

  logic signed [PROD_W-1:0] prod_q [LANES];
  logic signed [PROD_W-1:0] prod_d [LANES];
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [ACC_W-1:0]  bias, quot;
  logic [SAMPLE_W-1:0]      sat;
  logic                     last_res, fin_fire;

  logic                out_valid_q;
  logic [SAMPLE_W-1:0] out_data_q;
  logic                out_last_q;

  assign pop_o       = (state_q == ST_IDLE) && !q_empty_i;
  assign last_res    = !ctl_q.drain || (pos_q == '0);
  assign fin_fire    = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

  // one multiplier per tap; future mode picks the sample pos-k back
  always_comb begin
    logic [HIST_IDX_W-1:0]    idx;
    logic                     use_k;
    logic signed [PROD_W-1:0] c_ext, s_ext;
    for (int k = 0; k < LANES; k++) begin
      idx = pos_q - HIST_IDX_W'(k);
      if (ctl_q.kind == JOB_FUTURE) begin
        use_k = (32'(taps_i) > k) && (32'(pos_q) >= k);
        s_ext = PROD_W'($signed(hist_q[idx]));
      end else begin
        use_k = (32'(taps_i) > k);
        s_ext = PROD_W'($signed(hist_q[k]));
      end
      c_ext     = PROD_W'($signed(coef_i[k]));
      prod_d[k] = use_k ? c_ext * s_ext : '0;
    end
  end

  always_comb begin
    acc_d = '0;
    for (int k = 0; k < LANES; k++) begin
      acc_d = acc_d + ACC_W'(prod_q[k]);
    end
  end

  assign bias = acc_q[ACC_W-1] ?
                {{(ACC_W-COEF_FRAC_BITS){1'b0}}, {COEF_FRAC_BITS{1'b1}}} : '0;
  assign quot = (acc_q + bias) >>> COEF_FRAC_BITS;

  always_comb begin
    if ((&quot[ACC_W-1:SAMPLE_W-1]) || !(|quot[ACC_W-1:SAMPLE_W-1])) begin
      sat = quot[SAMPLE_W-1:0];
    end else begin
      sat = quot[ACC_W-1] ? SAMPLE_MIN : SAMPLE_MAX;
    end
  end

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          state_d = ST_MUL;
          pos_d   = job_pos_i;
        end
      end
      ST_MUL: state_d = ST_SUM;
      ST_SUM: state_d = ST_FIN;
      ST_FIN: begin
        if (fin_fire) begin
          if (last_res) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_MUL;
            pos_d   = pos_q - 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (fin_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    if (pop_o) begin
      hist_q <= job_hist_i;
      ctl_q  <= job_ctl_i;
    end
    if (state_q == ST_MUL) begin
      for (int k = 0; k < LANES; k++) begin
        prod_q[k] <= prod_d[k];
      end
    end
    if (state_q == ST_SUM) begin
      acc_q <= acc_d;
    end
    if (fin_fire) begin
      out_data_q <= (ctl_q.kind == JOB_PASS) ? hist_q[0] : sat;
      out_last_q <= ctl_q.blk_end && last_res;
    end
  end

endmodule

/* sv/block_fir_filter_two_direction.sv */
// Two-direction FIR filter top level: configuration registers, front end, queue, engine.
//
// Samples arrive on the s_axis group, one per transfer, tlast marking the last sample
// of a block. Filtered samples leave on the m_axis group, tlast marking the last result
// of the block. Taps, direction and coefficients are written through cfg_we_i, cfg_idx_i
// and cfg_data_i, by the user only while no sample is in flight; the block has no check.
// Past mode gives one result per sample. Future mode holds results back by tap count
// minus one samples and drains the tail after the last sample of a block; a tap count
// of zero passes samples through.
// The engine sequences multiply, sum and round/saturate steps for one result at a time,
// and again for each further result of a block-end drain. A two-entry job queue lets the
// input side keep accepting while the engine or the output is busy.
// Reset clears the history, queue, engine and configuration (coef_0 = 1.0, others 0,
// tap count 0, past mode). When the receiver stalls, the held result stays on m_axis,
// the engine waits on it, the queue fills and s_axis_tready drops.
module block_fir_filter_two_direction import fir2d_pkg::*; #(
  parameter int unsigned MAX_TAPS       = MAX_TAPS_DEF,
  parameter int unsigned COEF_FRAC_BITS = COEF_FRAC_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [SAMPLE_W-1:0]   s_axis_tdata,   // [31:0] sample
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [SAMPLE_W-1:0]   m_axis_tdata,   // [31:0] filtered
  output logic                  m_axis_tlast
);

  localparam int unsigned HIST_IDX_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int unsigned FILL_W     = $clog2(MAX_TAPS + 1);
  localparam int unsigned HIST_W     = MAX_TAPS * SAMPLE_W;
  localparam int unsigned JOB_W      = HIST_W + HIST_IDX_W + $bits(job_ctl_t);

  logic [TAP_CNT_W-1:0]            tap_count_q;
  logic                            direction_q;
  logic [NUM_COEF-1:0][COEF_W-1:0] coef_q;
  logic [FILL_W-1:0]               taps_eff;

  logic                              q_push, q_pop, q_full, q_empty;
  logic [MAX_TAPS-1:0][SAMPLE_W-1:0] f_hist, b_hist;
  logic [HIST_IDX_W-1:0]             f_pos, b_pos;
  job_ctl_t                          f_ctl, b_ctl;
  logic [JOB_W-1:0]                  q_wdata, q_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= '0;
      direction_q <= 1'b0;
      coef_q      <= (NUM_COEF*COEF_W)'(COEF0_RESET);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_TAP_COUNT: tap_count_q <= cfg_data_i[TAP_CNT_W-1:0];
        REG_DIRECTION: direction_q <= cfg_data_i[0];
        default: begin
          coef_q[COEF_IDX_W'(cfg_idx_i - CFG_IDX_W'(REG_COEF_0))] <= cfg_data_i[COEF_W-1:0];
        end
      endcase
    end
  end

  always_comb begin
    if (32'(tap_count_q) > MAX_TAPS) begin
      taps_eff = FILL_W'(MAX_TAPS);
    end else begin
      taps_eff = FILL_W'(tap_count_q);
    end
  end

  fir2d_front #(
    .MAX_TAPS (MAX_TAPS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .taps_i      (taps_eff),
    .direction_i (direction_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .sample_i    (s_axis_tdata),
    .blk_end_i   (s_axis_tlast),
    .q_full_i    (q_full),
    .push_o      (q_push),
    .job_hist_o  (f_hist),
    .job_pos_o   (f_pos),
    .job_ctl_o   (f_ctl)
  );

  assign q_wdata = {f_hist, f_pos, f_ctl};
  assign {b_hist, b_pos, b_ctl} = q_rdata;

  fir2d_queue #(
    .DATA_W (JOB_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  fir2d_back #(
    .MAX_TAPS       (MAX_TAPS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .taps_i      (taps_eff),
    .coef_i      (coef_q),
    .q_empty_i   (q_empty),
    .pop_o       (q_pop),
    .job_hist_i  (b_hist),
    .job_pos_i   (b_pos),
    .job_ctl_i   (b_ctl),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

`ifndef SYNTH
  a_queue_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("job pushed into a full queue");

  a_queue_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("job popped from an empty queue");

  a_pass_always_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (taps_eff == '0)) |-> q_push)
    else $error("pass-through sample transfer did not queue a job");
`endif

endmodule
